// ===== rtl/core/pbnm_pkg.sv =====
// ---------------------------------------------------------------------------
// pbnm_pkg
// Shared types and codes for the palette nearest-match unit.
// ---------------------------------------------------------------------------
package pbnm_pkg;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_MATCH = 2'd1,
      ACT_BLEND = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } color_type;

   // one queued command from front to back
   typedef struct packed {
      action_type action;
      logic [7:0] entry_index;
      color_type  color;
      logic [7:0] first_index;
      logic [7:0] second_index;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RDA,
      ST_RDB,
      ST_MIX,
      ST_SCAN,
      ST_LAST,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/core/pbnm_if.sv =====
// ---------------------------------------------------------------------------
// pbnm_req_if / pbnm_rsp_if
// Valid/ready channels for request and response words.
// ---------------------------------------------------------------------------
interface pbnm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] entry_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic [7:0] first_index;
   logic [7:0] second_index;
   modport source (output valid, action, entry_index, red, green, blue, alpha,
                   first_index, second_index, input ready);
   modport sink (input valid, action, entry_index, red, green, blue, alpha,
                 first_index, second_index, output ready);
endinterface

interface pbnm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] best_index;
   modport source (output valid, best_index, input ready);
   modport sink (input valid, best_index, output ready);
endinterface

// ===== rtl/core/pbnm_front.sv =====
// ---------------------------------------------------------------------------
// pbnm_front
// Accepts request words, drops unused actions, queues commands (2 deep).
// ---------------------------------------------------------------------------
module pbnm_front (
   input  logic             clock,
   input  logic             reset,
   pbnm_req_if.sink         req,
   output pbnm_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  logic             cmd_pop
);
   import pbnm_pkg::*;

   cmd_type    q_ff [2];
   cmd_type    in_cmd;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req.ready = (cnt_ff != 2'd2);
   assign in_cmd = '{action: action_type'(req.action), entry_index: req.entry_index,
                     color: '{alpha: req.alpha, blue: req.blue, green: req.green,
                              red: req.red},
                     first_index: req.first_index, second_index: req.second_index};
   assign push = req.valid && req.ready && (in_cmd.action != ACT_NONE);
   assign cmd = q_ff[rd_ff];
   assign cmd_valid = (cnt_ff != 2'd0);

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ cmd_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= in_cmd;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== rtl/core/pbnm_back.sv =====
// ---------------------------------------------------------------------------
// pbnm_back
// Palette memory, blend and sequential nearest-entry scan.
// ---------------------------------------------------------------------------
module pbnm_back #(
   parameter int ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  pbnm_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   pbnm_rsp_if.source       rsp
);
   import pbnm_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [8:0] LAST = 9'(ENTRIES - 1);

   color_type  mem [ENTRIES];
   color_type  rd_ff;
   color_type  rd_word;
   state_type  st_ff, st_in;
   cmd_type    cur_ff;
   color_type  a_ff, want_ff;
   logic [8:0] addr_ff, addr_in;   // index being read
   logic [8:0] cidx_ff;            // index of rd_ff
   logic [7:0] best_ff;
   logic [7:0] bdist_ff;
   logic       first_ff;
   logic       prev_scan_ff;       // rd_ff holds a scanned entry
   logic [9:0] sum;
   logic [7:0] gap;
   logic [7:0] out_ff;
   logic       ov_ff;
   logic       rd_ok_ff;

   function automatic logic [7:0] ad(input logic [7:0] a, input logic [7:0] b);
      ad = (a > b) ? a - b : b - a;
   endfunction

   assign sum = {2'b0, ad(rd_ff.red, want_ff.red)} + {2'b0, ad(rd_ff.green, want_ff.green)}
              + {2'b0, ad(rd_ff.blue, want_ff.blue)} + {2'b0, ad(rd_ff.alpha, want_ff.alpha)};
   assign gap = sum[9:2];
   assign rd_word = rd_ok_ff ? rd_ff : '0;
   assign rsp.valid = ov_ff;
   assign rsp.best_index = out_ff;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.action)
                  ACT_MATCH: st_in = ST_SCAN;
                  ACT_BLEND: st_in = ST_RDA;
                  default:   st_in = ST_IDLE;
               endcase
            end
         end
         ST_RDA:  st_in = ST_RDB;
         ST_RDB:  st_in = ST_MIX;
         ST_MIX:  st_in = ST_SCAN;
         ST_SCAN: if (addr_ff == LAST) st_in = ST_LAST;
         ST_LAST: st_in = ST_OUT;
         ST_OUT:  if (!ov_ff) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop = 1'b0;
      addr_in = addr_ff;
      case (st_ff)
         ST_IDLE: begin
            cmd_pop = cmd_valid;
            addr_in = (cmd_valid && cmd.action == ACT_BLEND) ? {1'b0, cmd.first_index}
                                                              : 9'd0;
         end
         ST_RDA:  addr_in = {1'b0, cur_ff.second_index};
         ST_RDB:  addr_in = 9'd0;
         ST_MIX:  addr_in = 9'd0;
         ST_SCAN: addr_in = addr_ff + 9'd1;
         default: addr_in = addr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_IDLE && cmd_valid && cmd.action == ACT_WRITE
          && {1'b0, cmd.entry_index} <= LAST) begin
         mem[cmd.entry_index[IW-1:0]] <= cmd.color;
      end
      rd_ff <= mem[addr_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      rd_ok_ff     <= (addr_ff <= LAST);
      cidx_ff      <= addr_ff;
      prev_scan_ff <= (st_ff == ST_SCAN);
      if (st_ff == ST_IDLE) begin
         cur_ff  <= cmd;
         want_ff <= cmd.color;
         first_ff <= 1'b1;
      end
      if (st_ff == ST_RDB) begin
         a_ff <= rd_word;
      end
      if (st_ff == ST_MIX) begin
         want_ff.red   <= {1'b0, a_ff.red[7:1]}   + {1'b0, rd_word.red[7:1]};
         want_ff.green <= {1'b0, a_ff.green[7:1]} + {1'b0, rd_word.green[7:1]};
         want_ff.blue  <= {1'b0, a_ff.blue[7:1]}  + {1'b0, rd_word.blue[7:1]};
         want_ff.alpha <= {1'b0, a_ff.alpha[7:1]} + {1'b0, rd_word.alpha[7:1]};
      end
      // compare the word read in the previous scan cycle
      if (prev_scan_ff) begin
         if (first_ff || gap < bdist_ff) begin
            bdist_ff <= gap;
            best_ff  <= cidx_ff[7:0];
         end
         first_ff <= 1'b0;
      end
      if (st_ff == ST_LAST) begin
         out_ff <= (first_ff || gap < bdist_ff) ? cidx_ff[7:0] : best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         addr_ff <= 9'd0;
         ov_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         addr_ff <= addr_in;
         if (st_ff == ST_LAST) begin
            ov_ff <= 1'b1;
         end else if (rsp.ready) begin
            ov_ff <= 1'b0;
         end
      end
   end
endmodule

// ===== rtl/core/palette_blend_nearest_match_unit.sv =====
// Matches and blends run as a sequential scan through the single palette read port
// and distance comparator; the next command starts only after the response is taken.
// Writes are done by the back end from its idle state.
// A 2-word queue lets requests be taken while a match runs.
// Reset (synchronous, active high) clears control; palette contents stay undefined.
// ---------------------------------------------------------------------------
// palette_blend_nearest_match_unit
// Palette store with nearest-color and blended-color match.
// ---------------------------------------------------------------------------
module palette_blend_nearest_match_unit #(
   parameter int PALETTE_ENTRIES = 256
) (
   input logic        clock,
   input logic        reset,
   pbnm_req_if.sink   req,
   pbnm_rsp_if.source rsp
);
   import pbnm_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   pbnm_front u_front (
      .clock, .reset, .req, .cmd, .cmd_valid, .cmd_pop
   );

   pbnm_back #(.ENTRIES(PALETTE_ENTRIES)) u_back (
      .clock, .reset, .cmd, .cmd_valid, .cmd_pop, .rsp
   );
endmodule

// ===== rtl/core/pbnm_checker.sv =====
// ---------------------------------------------------------------------------
// pbnm_checker
// Port-level checks for the palette match unit.
// ---------------------------------------------------------------------------
module pbnm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_best_index
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_index))
      else $error("response word dropped or changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("back-to-back responses faster than a scan");

   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("queue not empty after reset");
endmodule

bind palette_blend_nearest_match_unit pbnm_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_best_index(rsp.best_index)
);

// ===== bench/pbnm_match_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbnm_match_checker
// Watches the request and response channels of the palette match unit, keeps
// its own palette copy, predicts the nearest index for each match or blend
// word and compares it against the returned words in order.
// ---------------------------------------------------------------------------
module pbnm_match_checker (
   input  logic       clock,
   input  logic       reset,
   pbnm_req_if        req,
   pbnm_rsp_if        rsp,
   output int         mismatches,
   output int         waiting
);
   import pbnm_pkg::*;

   color_type  palette_copy [256];
   logic [7:0] best_index_queue [$];

   function automatic logic [7:0] nearest_entry(color_type want);
      logic [7:0] best;
      int         best_dist;
      int         gap;
      color_type  c;
      best = 8'd0;
      best_dist = 0;
      for (int i = 0; i < 256; i++) begin
         c = palette_copy[i];
         gap = (((c.red   > want.red)   ? c.red   - want.red   : want.red   - c.red)
               + ((c.green > want.green) ? c.green - want.green : want.green - c.green)
               + ((c.blue  > want.blue)  ? c.blue  - want.blue  : want.blue  - c.blue)
               + ((c.alpha > want.alpha) ? c.alpha - want.alpha : want.alpha - c.alpha)) >> 2;
         if (i == 0 || gap < best_dist) begin
            best_dist = gap;
            best = i[7:0];
         end
      end
      return best;
   endfunction

   function automatic color_type blend_color(color_type a, color_type b);
      color_type m;
      m.red   = (a.red   >> 1) + (b.red   >> 1);
      m.green = (a.green >> 1) + (b.green >> 1);
      m.blue  = (a.blue  >> 1) + (b.blue  >> 1);
      m.alpha = (a.alpha >> 1) + (b.alpha >> 1);
      return m;
   endfunction

   always @(posedge clock) begin
      color_type  word_color;
      logic [7:0] want;
      if (reset) begin
         mismatches = 0;
         for (int i = 0; i < 256; i++) palette_copy[i] = '0;
         best_index_queue.delete();
      end else begin
         if (req.valid && req.ready) begin
            word_color = {req.alpha, req.blue, req.green, req.red};
            case (action_type'(req.action))
               ACT_WRITE: palette_copy[req.entry_index] = word_color;
               ACT_MATCH: best_index_queue.push_back(nearest_entry(word_color));
               ACT_BLEND: best_index_queue.push_back(nearest_entry(blend_color(
                  palette_copy[req.first_index], palette_copy[req.second_index])));
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (best_index_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected rsp word: best_index=%0d", rsp.best_index);
            end else begin
               want = best_index_queue.pop_front();
               if (rsp.best_index !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("best_index mismatch: expected %0d, actual %0d",
                              want, rsp.best_index);
               end
            end
         end
      end
      waiting = best_index_queue.size();
   end

endmodule

// ===== bench/palette_blend_nearest_match_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palette_blend_nearest_match_unit_test
// Fills the palette, then runs directed and random write, match, blend and
// no-op words with random idling on both channels; the checker compares.
// ---------------------------------------------------------------------------
module palette_blend_nearest_match_unit_test;
   import pbnm_pkg::*;

   logic clock = 1'b0;
   logic reset;
   int   req_idle;
   int   rsp_idle;
   int   mismatches;
   int   waiting;

   pbnm_req_if req ();
   pbnm_rsp_if rsp ();

   palette_blend_nearest_match_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   pbnm_match_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .mismatches (mismatches),
      .waiting    (waiting)
   );

   always #4 clock = ~clock;

   always @(negedge clock) rsp.ready <= ($urandom_range(99) >= rsp_idle);

   initial begin
      #40ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [7:0] rand8();
      return 8'($urandom_range(255));
   endfunction

   // mostly full range, sometimes near the extremes to provoke ties
   function automatic logic [7:0] pick_channel();
      if ($urandom_range(3) == 0) begin
         if ($urandom_range(1) == 1) return 8'($urandom_range(3));
         return 8'(252 + $urandom_range(3));
      end
      return rand8();
   endfunction

   task automatic send_word(action_type act, logic [7:0] idx, logic [7:0] r,
                            logic [7:0] g, logic [7:0] b, logic [7:0] a,
                            logic [7:0] f, logic [7:0] s);
      while ($urandom_range(99) < req_idle) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid        <= 1'b1;
      req.action       <= act;
      req.entry_index  <= idx;
      req.red          <= r;
      req.green        <= g;
      req.blue         <= b;
      req.alpha        <= a;
      req.first_index  <= f;
      req.second_index <= s;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30)
         send_word(ACT_WRITE, rand8(), pick_channel(), pick_channel(),
                   pick_channel(), pick_channel(), rand8(), rand8());
      else if (pick < 60)
         send_word(ACT_MATCH, rand8(), pick_channel(), pick_channel(),
                   pick_channel(), pick_channel(), rand8(), rand8());
      else if (pick < 92)
         send_word(ACT_BLEND, rand8(), rand8(), rand8(), rand8(), rand8(), rand8(),
                   rand8());
      else
         send_word(ACT_NONE, rand8(), rand8(), rand8(), rand8(), rand8(), rand8(),
                   rand8());
   endtask

   initial begin
      int limit;
      reset     = 1'b1;
      req_idle  = 34;
      rsp_idle  = 45;
      req.valid = 1'b0;
      req.action = ACT_NONE;
      req.entry_index = '0;
      req.red = '0;
      req.green = '0;
      req.blue = '0;
      req.alpha = '0;
      req.first_index = '0;
      req.second_index = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every entry written before any match; duplicates of 0 and 255 force ties
      for (int i = 0; i < 256; i++) begin
         if (i < 4)
            send_word(ACT_WRITE, 8'(i), 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
         else if (i > 251)
            send_word(ACT_WRITE, 8'(i), 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
         else
            send_word(ACT_WRITE, 8'(i), pick_channel(), pick_channel(), pick_channel(),
                      pick_channel(), 8'h00, 8'h00);
      end
      send_word(ACT_MATCH, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff);
      send_word(ACT_MATCH, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00);
      send_word(ACT_MATCH, 8'h00, 8'h01, 8'h02, 8'h01, 8'h00, 8'h00, 8'h00);
      send_word(ACT_MATCH, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00);
      send_word(ACT_BLEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff);
      send_word(ACT_BLEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff);
      send_word(ACT_BLEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_word(ACT_BLEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h55, 8'haa);
      send_word(ACT_NONE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
      send_word(ACT_WRITE, 8'h00, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h00, 8'h00);
      send_word(ACT_MATCH, 8'h00, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h00, 8'h00);
      send_word(ACT_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_word(ACT_BLEND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hfe);

      for (int i = 0; i < 980; i++) begin
         if (i == 148) begin
            req_idle = 45;
            rsp_idle = 34;
         end else if (i == 565) begin
            req_idle = 0;
            rsp_idle = 0;
         end
         send_random();
      end
      req.valid <= 1'b0;

      limit = 0;
      while (waiting != 0 && limit < 100000) begin
         @(posedge clock);
         limit++;
      end
      repeat (300) @(posedge clock);
      if (mismatches == 0 && waiting == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pbnm_pkg.sv
rtl/core/pbnm_if.sv
rtl/core/pbnm_front.sv
rtl/core/pbnm_back.sv
rtl/core/palette_blend_nearest_match_unit.sv
rtl/core/pbnm_checker.sv
bench/pbnm_match_checker.sv
bench/palette_blend_nearest_match_unit_test.sv
